@@ hdl/vps_pkg.sv @@
// ----------------------------------------------------------------------------
// vps_pkg
// Shared types, constants and helpers of the Voronoi pixel shader.
// ----------------------------------------------------------------------------
package vps_pkg;

  // Field widths of the item channels
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned PAL_W   = 3;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned DIST_W  = 2 * COORD_W + 1;

  // Shading constants
  localparam logic [COLOR_W-1:0] EDGE_COLOR = 24'h0B0E16;
  localparam logic [7:0]         SHADE_MAX  = 8'd255;
  localparam logic [7:0]         SHADE_MIN  = 8'd70;
  // Distance at which d/90 exceeds SHADE_MAX - SHADE_MIN (186 * 90)
  localparam logic [DIST_W-1:0]  FAR_LIMIT  = 21'd16740;
  // Reciprocal of 90 at 2^21, exact for every distance below FAR_LIMIT
  localparam logic [14:0]        RECIP_90   = 15'd23302;
  localparam int unsigned        RECIP_SH   = 21;

  localparam logic [COLOR_W-1:0] PALETTE [8] = '{
    24'hD4AF37, 24'h4E93C8, 24'hC8664E, 24'h5FA87A,
    24'h9A6FC0, 24'hC9A24B, 24'h4EA0A0, 24'hB0526F
  };

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  // One classified command between front and back
  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   site_index;
    logic [COORD_W-1:0] site_x;
    logic [COORD_W-1:0] site_y;
    logic [PAL_W-1:0]   site_palette;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               in_row;
  } vps_cmd_t;

  // Front to queue
  typedef struct packed {
    logic     push;
    vps_cmd_t cmd;
  } vps_qpush_t;

  // Queue head to back
  typedef struct packed {
    logic     avail;
    vps_cmd_t cmd;
  } vps_qhead_t;

  // One site table entry
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PAL_W-1:0]   pal;
  } vps_site_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_QUOT,
    BK_SCALE,
    BK_OUT
  } bk_state_t;

  // Exact floor(x / 255) for any x below 255 * 256, the 8-bit result range
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage

@@ hdl/vps_if.sv @@
// ----------------------------------------------------------------------------
// vps_in_if / vps_out_if
// Valid/ready channels for shader commands and shaded pixels.
// ----------------------------------------------------------------------------
interface vps_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [4:0] site_index;
  logic [9:0] site_x;
  logic [9:0] site_y;
  logic [2:0] site_palette;
  logic [9:0] pixel_x;
  logic [9:0] pixel_y;

  modport source (
    output valid, kind, site_index, site_x, site_y, site_palette, pixel_x, pixel_y,
    input  ready
  );
  modport sink (
    input  valid, kind, site_index, site_x, site_y, site_palette, pixel_x, pixel_y,
    output ready
  );
endinterface

interface vps_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_color;
  logic [4:0]  nearest_site;
  logic        is_edge;

  modport source (
    output valid, pixel_color, nearest_site, is_edge,
    input  ready
  );
  modport sink (
    input  valid, pixel_color, nearest_site, is_edge,
    output ready
  );
endinterface

@@ hdl/vps_front.sv @@
// ----------------------------------------------------------------------------
// vps_front
// Accepts items, drops loads beyond the site table, tags columns outside the
// row store and pushes the rest into the command queue.
// ----------------------------------------------------------------------------
module vps_front #(
  parameter int unsigned NUM_SITES = 28,
  parameter int unsigned CANVAS_W  = 1024
) (
  vps_in_if.sink            in_ch,
  input  logic              q_full,
  output vps_pkg::vps_qpush_t q_push
);
  import vps_pkg::*;

  logic accept;
  logic idx_ok;

  // Take an item whenever the queue has room
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // Classify: loads beyond the table are dropped here
  assign idx_ok = 32'(in_ch.site_index) < NUM_SITES;

  always_comb begin
    q_push.cmd.op           = op_t'(in_ch.kind);
    q_push.cmd.site_index   = in_ch.site_index;
    q_push.cmd.site_x       = in_ch.site_x;
    q_push.cmd.site_y       = in_ch.site_y;
    q_push.cmd.site_palette = in_ch.site_palette;
    q_push.cmd.pixel_x      = in_ch.pixel_x;
    q_push.cmd.pixel_y      = in_ch.pixel_y;
    q_push.cmd.in_row       = 32'(in_ch.pixel_x) < CANVAS_W;
    q_push.push             = accept && (q_push.cmd.op == OP_PIXEL || idx_ok);
  end

endmodule

@@ hdl/vps_queue.sv @@
// ----------------------------------------------------------------------------
// vps_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module vps_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  vps_pkg::vps_qpush_t q_push,
  output logic                q_full,
  output vps_pkg::vps_qhead_t q_head,
  input  logic                q_pop
);
  import vps_pkg::*;

  vps_cmd_t    mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_push;
  logic        do_pop;

  assign q_full       = cnt_r == 2'd2;
  assign q_head.avail = cnt_r != 2'd0;
  assign q_head.cmd   = mem_r[rd_ptr_r];

  assign do_push = q_push.push && !q_full;
  assign do_pop  = q_pop && q_head.avail;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.cmd;
    end
  end

endmodule

@@ hdl/vps_back.sv @@
// ----------------------------------------------------------------------------
// vps_back
// Executes queued commands: writes the site table, scans all sites for the
// nearest one, checks cell borders, shades and holds the result.
// ----------------------------------------------------------------------------
module vps_back #(
  parameter int unsigned NUM_SITES = 28,
  parameter int unsigned CANVAS_W  = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vps_pkg::vps_qhead_t q_head,
  output logic                q_pop,
  vps_out_if.source           out_ch
);
  import vps_pkg::*;

  localparam int unsigned SW = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;
  localparam int unsigned CW = $clog2(NUM_SITES + 1);
  localparam int unsigned AW = $clog2(CANVAS_W);

  // Site table and row-above store
  vps_site_t        site_mem [NUM_SITES];
  logic [IDX_W-1:0] row_mem  [CANVAS_W];
  vps_site_t        site_rd_r;
  logic [IDX_W-1:0] row_rd_r;

  bk_state_t state_r, state_nxt;

  // Control
  logic          pop_load;
  logic          pop_pixel;
  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic          rd_last;
  logic          out_load;

  // Pixel context
  logic [COORD_W-1:0] px_r;
  logic [COORD_W-1:0] py_r;
  logic               in_row_r;
  logic [CW-1:0]      rd_cnt_r;

  // Scan pipeline
  logic                 rdv_r, rd_last_r;
  logic [SW-1:0]        rd_idx_r;
  logic [COORD_W-1:0]   dx, dy;
  logic [2*COORD_W-1:0] sqx_r, sqy_r;
  logic                 sqv_r, sq_last_r;
  logic [SW-1:0]        sq_idx_r;
  logic [PAL_W-1:0]     sq_pal_r;
  logic [DIST_W-1:0]    sq_dist;
  logic [DIST_W-1:0]    best_d_r;
  logic [SW-1:0]        best_r;
  logic [PAL_W-1:0]     best_pal_r;
  logic [IDX_W-1:0]     best5;

  // Shading
  logic [29:0]        qprod_r;
  logic               far_r;
  logic               edge_r;
  logic [8:0]         quot;
  logic [7:0]         shade;
  logic [COLOR_W-1:0] base;
  logic [15:0]        chan_r [3];
  logic [COLOR_W-1:0] color;
  logic [IDX_W-1:0]   left_r;

  // Output register
  logic               out_valid_r;
  logic [COLOR_W-1:0] out_color_r;
  logic [IDX_W-1:0]   out_site_r;
  logic               out_edge_r;

  assign best5 = IDX_W'(best_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_head.avail && q_head.cmd.op == OP_PIXEL) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (sqv_r && sq_last_r) begin
          state_nxt = BK_QUOT;
        end
      end
      BK_QUOT:  state_nxt = BK_SCALE;
      BK_SCALE: state_nxt = BK_OUT;
      BK_OUT: begin
        if (out_load) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop     = 1'b0;
    pop_load  = 1'b0;
    pop_pixel = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    rd_last   = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        q_pop     = q_head.avail;
        pop_load  = q_head.avail && q_head.cmd.op == OP_LOAD;
        pop_pixel = q_head.avail && q_head.cmd.op == OP_PIXEL;
        rd_en     = pop_pixel;
        rd_last   = NUM_SITES == 1;
      end
      BK_SCAN: begin
        rd_en   = rd_cnt_r < CW'(NUM_SITES);
        rd_addr = rd_cnt_r[SW-1:0];
        rd_last = rd_cnt_r == CW'(NUM_SITES - 1);
      end
      BK_OUT: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Site table: write on load, read one entry per scan cycle
  always_ff @(posedge clk) begin
    if (pop_load) begin
      site_mem[SW'(q_head.cmd.site_index)] <= '{
        x:   q_head.cmd.site_x,
        y:   q_head.cmd.site_y,
        pal: q_head.cmd.site_palette
      };
    end
    if (rd_en) begin
      site_rd_r <= site_mem[rd_addr];
    end
  end

  // Row-above store: read at pixel start, write at result
  always_ff @(posedge clk) begin
    if (pop_pixel) begin
      row_rd_r <= row_mem[AW'(q_head.cmd.pixel_x)];
    end
    if (out_load && in_row_r) begin
      row_mem[AW'(px_r)] <= best5;
    end
  end

  // Latch pixel context and advance the read counter
  always_ff @(posedge clk) begin
    if (pop_pixel) begin
      px_r     <= q_head.cmd.pixel_x;
      py_r     <= q_head.cmd.pixel_y;
      in_row_r <= q_head.cmd.in_row;
      rd_cnt_r <= CW'(1);
    end else if (rd_en) begin
      rd_cnt_r <= rd_cnt_r + CW'(1);
    end
  end

  // Scan pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r <= 1'b0;
      sqv_r <= 1'b0;
    end else begin
      rdv_r <= rd_en;
      sqv_r <= rdv_r;
    end
  end

  // Squared distance components
  always_comb begin
    dx = (px_r >= site_rd_r.x) ? px_r - site_rd_r.x : site_rd_r.x - px_r;
    dy = (py_r >= site_rd_r.y) ? py_r - site_rd_r.y : site_rd_r.y - py_r;
  end

  assign sq_dist = DIST_W'(sqx_r) + DIST_W'(sqy_r);

  always_ff @(posedge clk) begin
    rd_last_r <= rd_last;
    rd_idx_r  <= rd_addr;
    if (rdv_r) begin
      sqx_r     <= (2*COORD_W)'(dx) * (2*COORD_W)'(dx);
      sqy_r     <= (2*COORD_W)'(dy) * (2*COORD_W)'(dy);
      sq_last_r <= rd_last_r;
      sq_idx_r  <= rd_idx_r;
      sq_pal_r  <= site_rd_r.pal;
    end
    // Keep the nearest site; strict compare keeps the lower index on ties
    if (sqv_r && (sq_idx_r == '0 || sq_dist < best_d_r)) begin
      best_d_r   <= sq_dist;
      best_r     <= sq_idx_r;
      best_pal_r <= sq_pal_r;
    end
  end

  // Shade factor and border check
  always_comb begin
    quot  = qprod_r[RECIP_SH +: 9];
    shade = far_r ? SHADE_MIN : 8'(9'(SHADE_MAX) - quot);
    base  = PALETTE[best_pal_r];
    color = edge_r ? EDGE_COLOR
                   : {div255(chan_r[2]), div255(chan_r[1]), div255(chan_r[0])};
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_QUOT) begin
      qprod_r <= 30'(best_d_r[14:0]) * 30'(RECIP_90);
      far_r   <= best_d_r >= FAR_LIMIT;
      edge_r  <= (px_r != '0 && left_r != best5) ||
                 (py_r != '0 && in_row_r && row_rd_r != best5);
    end
    if (state_r == BK_SCALE) begin
      chan_r[2] <= 16'(base[23:16]) * 16'(shade);
      chan_r[1] <= 16'(base[15:8]) * 16'(shade);
      chan_r[0] <= 16'(base[7:0]) * 16'(shade);
    end
  end

  // Left neighbor site
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (out_load) begin
      left_r <= best5;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_color_r <= color;
      out_site_r  <= best5;
      out_edge_r  <= edge_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_color  = out_color_r;
  assign out_ch.nearest_site = out_site_r;
  assign out_ch.is_edge      = out_edge_r;

endmodule

@@ hdl/voronoi_pixel_shader_top.sv @@
// ----------------------------------------------------------------------------
// voronoi_pixel_shader_top
// Nearest-site raster shader: loads a site table, then colors pixels by
// their closest site, darkening cell borders.
// ----------------------------------------------------------------------------
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    kind, site_*, pixel_x, pixel_y
//   out_ch    out  valid/ready    pixel_color, nearest_site, is_edge
//
// A load item is written to the site table from the queue head. A pixel item
// is paced by the site scan: one site table read and one distance compare per
// cycle. A two-entry queue lets the front take items while the back works, and
// the output register holds a result while the next pixel scans.
// Reset clears control only; site and row stores hold nothing until written.
// ----------------------------------------------------------------------------
module voronoi_pixel_shader_top #(
  parameter int unsigned NUM_SITES = 28,
  parameter int unsigned CANVAS_W  = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  vps_in_if.sink    in_ch,
  vps_out_if.source out_ch
);
  import vps_pkg::*;

  vps_qpush_t q_push;
  vps_qhead_t q_head;
  logic       q_full;
  logic       q_pop;

  vps_front #(
    .NUM_SITES (NUM_SITES),
    .CANVAS_W  (CANVAS_W)
  ) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push)
  );

  vps_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  vps_back #(
    .NUM_SITES (NUM_SITES),
    .CANVAS_W  (CANVAS_W)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

@@ tb/tb_voronoi_pixel_shader_top.sv @@
// ----------------------------------------------------------------------------
// tb_voronoi_pixel_shader_top
// Self-checking bench for the Voronoi pixel shader. A queue of site loads and
// pixel items feeds a valid/ready driver. A shading predictor follows every
// accepted item and queues the color, site and border flag it expects. A
// monitor checks each result against that queue. Both sides idle at random,
// and the receiver holds off once long enough to back up the block.
// ----------------------------------------------------------------------------
module tb_voronoi_pixel_shader_top;
  import vps_pkg::*;

  localparam int unsigned NUM_SITES   = 28;
  localparam int unsigned CANVAS_W    = 1024;
  localparam int          COORD_MAX   = 1023;
  localparam int          ITEM_TARGET = 2000;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          TAIL_CYCLES = 100;
  localparam int          IDLE_PCT    = 16;
  localparam int          CALM_FROM   = 20000;
  localparam int          CALM_TO     = 32000;
  localparam int          HOLD_AT     = 3000;
  localparam int          HOLD_LEN    = 600;

  // Shading constants of the predictor
  localparam logic [COLOR_W-1:0] DARK_BORDER = 24'h0B0E16;
  localparam int unsigned        SHADE_DIV   = 90;
  localparam int unsigned        SHADE_FLOOR = 70;
  localparam int unsigned        SHADE_TOP   = 255;
  localparam logic [COLOR_W-1:0] BASE_COLORS [8] = '{
    24'hD4AF37, 24'h4E93C8, 24'hC8664E, 24'h5FA87A,
    24'h9A6FC0, 24'hC9A24B, 24'h4EA0A0, 24'hB0526F
  };

  typedef struct {
    op_t                kind;
    logic [IDX_W-1:0]   site_index;
    logic [COORD_W-1:0] site_x;
    logic [COORD_W-1:0] site_y;
    logic [PAL_W-1:0]   site_palette;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } shader_cmd_t;

  typedef struct {
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   site;
    logic               border;
  } shaded_px_t;

  logic clk;
  logic rst_n;

  vps_in_if  in_ch ();
  vps_out_if out_ch ();

  voronoi_pixel_shader_top #(
    .NUM_SITES(NUM_SITES),
    .CANVAS_W (CANVAS_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  shader_cmd_t pending_cmds [$];
  shaded_px_t  pixels_due [$];
  int          fail_count = 0;

  // Predictor copy of the block state
  logic [COORD_W-1:0] site_x_mem   [NUM_SITES];
  logic [COORD_W-1:0] site_y_mem   [NUM_SITES];
  logic [PAL_W-1:0]   site_pal_mem [NUM_SITES];
  logic [IDX_W-1:0]   left_mem;
  logic [IDX_W-1:0]   above_mem    [CANVAS_W];

  // Columns already shaded once, so the row above is known there
  bit col_seen [CANVAS_W];

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset and known input levels
  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.kind          = OP_LOAD;
    in_ch.site_index    = '0;
    in_ch.site_x        = '0;
    in_ch.site_y        = '0;
    in_ch.site_palette  = '0;
    in_ch.pixel_x       = '0;
    in_ch.pixel_y       = '0;
    out_ch.ready        = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Watchdog
  always @(posedge clk) begin
    static int cycle_count = 0;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_voronoi_pixel_shader_top NOT OK");
      $finish;
    end
  end

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic push_load(int idx, int x, int y, int pal);
    shader_cmd_t cmd;
    cmd.kind         = OP_LOAD;
    cmd.site_index   = IDX_W'(idx);
    cmd.site_x       = COORD_W'(clamp_coord(x));
    cmd.site_y       = COORD_W'(clamp_coord(y));
    cmd.site_palette = PAL_W'(pal);
    cmd.pixel_x      = COORD_W'($urandom);
    cmd.pixel_y      = COORD_W'($urandom);
    pending_cmds.push_back(cmd);
  endtask

  // Keep to row zero where the column has no known site above
  task automatic push_pixel(int x, int y);
    shader_cmd_t cmd;
    cmd.kind         = OP_PIXEL;
    cmd.site_index   = IDX_W'($urandom);
    cmd.site_x       = COORD_W'($urandom);
    cmd.site_y       = COORD_W'($urandom);
    cmd.site_palette = PAL_W'($urandom);
    cmd.pixel_x      = COORD_W'(x);
    cmd.pixel_y      = col_seen[x] ? COORD_W'(y) : '0;
    col_seen[x]      = 1'b1;
    pending_cmds.push_back(cmd);
  endtask

  // Reload the whole table around a center, with some coincident sites
  task automatic load_sites_near(int cx, int cy, int spread);
    int px;
    int py;
    px = cx;
    py = cy;
    for (int i = 0; i < NUM_SITES; i++) begin
      if (i == 0 || $urandom_range(0, 7) != 0) begin
        px = clamp_coord(cx + jitter(spread));
        py = clamp_coord(cy + jitter(spread));
      end
      push_load(i, px, py, $urandom_range(0, 7));
    end
  endtask

  // Raster scan of a window, seeding unknown columns on row zero first
  task automatic raster_frame(int x0, int y0, int w, int h);
    if (y0 > 0) begin
      for (int x = x0; x < x0 + w; x++) begin
        if (!col_seen[x]) push_pixel(x, 0);
      end
    end
    for (int y = y0; y < y0 + h; y++) begin
      for (int x = x0; x < x0 + w; x++) push_pixel(x, y);
    end
  endtask

  // Stimulus and end of run
  initial begin
    int cx;
    int cy;
    int w;
    int h;
    int x0;
    int y0;
    int pick;
    int n;

    // Site table: corners, a row of sites, one coincident pair
    for (int i = 0; i < NUM_SITES; i++) begin
      if (i == 0) push_load(i, 0, 0, 0);
      else if (i == NUM_SITES - 1) push_load(i, COORD_MAX, COORD_MAX, 7);
      else if (i == 9) push_load(i, 5 * 36 + 10, 500, 1);
      else push_load(i, i * 36 + 10, 500, i % 8);
    end
    // Loads past the table must leave it alone
    push_load(28, COORD_MAX, 0, 3);
    push_load(31, COORD_MAX, 0, 5);
    push_pixel(0, 0);
    push_pixel(COORD_MAX, 0);
    push_pixel(COORD_MAX, COORD_MAX);
    // Borders on a tiny window, then equal-distance ties
    raster_frame(62, 0, 5, 2);
    push_pixel(64, 500);
    push_pixel(190, 0);
    push_pixel(190, 500);

    cx = 512;
    cy = 512;
    while (pending_cmds.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 3) == 0) begin
          cx = $urandom_range(0, COORD_MAX);
          cy = $urandom_range(0, COORD_MAX);
          load_sites_near(cx, cy,
                          ($urandom_range(0, 7) == 0) ? COORD_MAX : $urandom_range(16, 160));
        end
        w  = $urandom_range(3, 20);
        h  = $urandom_range(2, 6);
        x0 = clamp_coord(cx - w / 2 + jitter(40));
        y0 = clamp_coord(cy - h / 2 + jitter(40));
        if ($urandom_range(0, 9) == 0) x0 = CANVAS_W - w;
        if ($urandom_range(0, 9) == 0) y0 = CANVAS_W - h;
        if ($urandom_range(0, 4) == 0) y0 = 0;
        if (x0 > int'(CANVAS_W) - w) x0 = CANVAS_W - w;
        if (y0 > int'(CANVAS_W) - h) y0 = CANVAS_W - h;
        raster_frame(x0, y0, w, h);
      end else if (pick < 85) begin
        n = $urandom_range(1, 8);
        repeat (n) push_pixel($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) push_load($urandom_range(0, 31), cx + jitter(120), cy + jitter(120),
                             $urandom_range(0, 7));
      end
    end

    // Drain, then give the block time to show any stray result
    @(posedge rst_n);
    while (pending_cmds.size() > 0 || in_ch.valid || pixels_due.size() > 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_voronoi_pixel_shader_top OK");
    end else begin
      $display("tb_voronoi_pixel_shader_top NOT OK");
    end
    $finish;
  end

  // Driver: offer the next item once the current one is taken
  always @(posedge clk) begin
    static int tx_cycles = 0;
    shader_cmd_t cmd;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      tx_cycles++;
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_cmds.size() > 0 &&
            ((tx_cycles >= CALM_FROM && tx_cycles < CALM_TO) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          cmd = pending_cmds.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.kind         <= cmd.kind;
          in_ch.site_index   <= cmd.site_index;
          in_ch.site_x       <= cmd.site_x;
          in_ch.site_y       <= cmd.site_y;
          in_ch.site_palette <= cmd.site_palette;
          in_ch.pixel_x      <= cmd.pixel_x;
          in_ch.pixel_y      <= cmd.pixel_y;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Shading predictor: update the table or queue the expected pixel
  always @(posedge clk) begin
    int unsigned        dx;
    int unsigned        dy;
    int unsigned        sq_len;
    int unsigned        best_len;
    int unsigned        quot;
    int unsigned        shade;
    int unsigned        chan;
    int unsigned        px;
    int unsigned        py;
    logic [IDX_W-1:0]   best;
    logic               border;
    logic [COLOR_W-1:0] base;
    logic [COLOR_W-1:0] color;
    shaded_px_t         due;
    if (!rst_n) begin
      left_mem = '0;
    end else if (in_ch.valid && in_ch.ready) begin
      if (in_ch.kind == OP_LOAD) begin
        // Drop loads past the end of the table
        if (in_ch.site_index < NUM_SITES) begin
          site_x_mem[in_ch.site_index]   = in_ch.site_x;
          site_y_mem[in_ch.site_index]   = in_ch.site_y;
          site_pal_mem[in_ch.site_index] = in_ch.site_palette;
        end
      end else begin
        px       = in_ch.pixel_x;
        py       = in_ch.pixel_y;
        best     = '0;
        best_len = 32'hFFFF_FFFF;
        // Strict compare keeps the lower index on a tie
        for (int i = 0; i < NUM_SITES; i++) begin
          dx     = (px >= site_x_mem[i]) ? px - site_x_mem[i] : site_x_mem[i] - px;
          dy     = (py >= site_y_mem[i]) ? py - site_y_mem[i] : site_y_mem[i] - py;
          sq_len = dx * dx + dy * dy;
          if (sq_len < best_len) begin
            best_len = sq_len;
            best     = IDX_W'(i);
          end
        end
        border = (px > 0 && left_mem != best) ||
                 (py > 0 && px < CANVAS_W && above_mem[px] != best);
        if (border) begin
          color = DARK_BORDER;
        end else begin
          quot  = best_len / SHADE_DIV;
          shade = (quot > SHADE_TOP - SHADE_FLOOR) ? SHADE_FLOOR : SHADE_TOP - quot;
          base  = BASE_COLORS[site_pal_mem[best]];
          color = '0;
          for (int pos = 0; pos < COLOR_W; pos += 8) begin
            chan  = base[pos +: 8];
            color[pos +: 8] = 8'((chan * shade) / SHADE_TOP);
          end
        end
        left_mem = best;
        if (px < CANVAS_W) above_mem[px] = best;
        due.color  = color;
        due.site   = best;
        due.border = border;
        pixels_due.push_back(due);
      end
    end
  end

  // Monitor: check each result, stall at random and once for a long stretch
  always @(posedge clk) begin
    static int rx_cycles = 0;
    static int hold_left = 0;
    shaded_px_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      rx_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel: color %h site %0d border %0b",
                 out_ch.pixel_color, out_ch.nearest_site, out_ch.is_edge);
          fail_count++;
        end else begin
          want = pixels_due.pop_front();
          if (out_ch.pixel_color !== want.color) begin
            $error("pixel_color: expected %h, got %h", want.color, out_ch.pixel_color);
            fail_count++;
          end
          if (out_ch.nearest_site !== want.site) begin
            $error("nearest_site: expected %0d, got %0d", want.site, out_ch.nearest_site);
            fail_count++;
          end
          if (out_ch.is_edge !== want.border) begin
            $error("is_edge: expected %0b, got %0b", want.border, out_ch.is_edge);
            fail_count++;
          end
        end
      end
      if (rx_cycles == HOLD_AT) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_cycles >= CALM_FROM && rx_cycles < CALM_TO) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

endmodule
